// ----- sv/md5m_pkg.sv -----
`timescale 1ns / 1ps
package md5m_pkg;

   localparam int StepCount    = 64;
   localparam int MaxWordBytes = 10;
   localparam int MinWordBytes = 3;

   localparam logic [2:0] RegTargetA    = 3'd0;
   localparam logic [2:0] RegTargetB    = 3'd1;
   localparam logic [2:0] RegTargetC    = 3'd2;
   localparam logic [2:0] RegTargetD    = 3'd3;
   localparam logic [2:0] RegWordLength = 3'd4;
   localparam logic [2:0] RegPrefix     = 3'd5;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;
   localparam logic [7:0]  PadByte = 8'h80;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] block_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } state_type;

   function automatic word_type step_const(input logic [5:0] i);
      word_type k;
      case (i)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] step_shift(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

   // Message word index used by step i.
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0:    g = i[3:0];
         2'd1:    g = 4'((5 * i) + 1);
         2'd2:    g = 4'((3 * i) + 5);
         default: g = 4'(7 * i);
      endcase
      return g;
   endfunction

endpackage

// ----- sv/md5m_block_builder.sv -----
`timescale 1ns / 1ps
module md5m_block_builder
   import md5m_pkg::*;
(
   input  logic [63:0] candidate,
   input  logic [3:0]  word_length,
   input  logic [15:0] prefix_bytes,
   output block_type   block
);

   logic [3:0]      len;
   logic [7:0]      bytes [64];
   logic [6:0]      bit_len;

   always_comb begin
      if (word_length < 4'(MinWordBytes)) begin
         len = 4'(MinWordBytes);
      end else if (word_length > 4'(MaxWordBytes)) begin
         len = 4'(MaxWordBytes);
      end else begin
         len = word_length;
      end
      bit_len = {len, 3'b000};
      for (int i = 0; i < 64; i++) begin
         bytes[i] = 8'h00;
      end
      bytes[0] = prefix_bytes[7:0];
      bytes[1] = prefix_bytes[15:8];
      for (int i = 0; i < MaxWordBytes - 2; i++) begin
         if (4'(i + 2) < len) begin
            bytes[i + 2] = candidate[8 * i +: 8];
         end
      end
      for (int i = MinWordBytes; i <= MaxWordBytes; i++) begin
         if (len == 4'(i)) begin
            bytes[i] = PadByte;
         end
      end
      bytes[56] = {1'b0, bit_len};
      for (int w = 0; w < 16; w++) begin
         block[w] = {bytes[4 * w + 3], bytes[4 * w + 2], bytes[4 * w + 1], bytes[4 * w]};
      end
   end

endmodule

// ----- sv/md5m_step.sv -----
`timescale 1ns / 1ps
module md5m_step
   import md5m_pkg::*;
(
   input  logic [5:0] step,
   input  state_type  st_in,
   input  block_type  blk,
   output state_type  st_out
);

   word_type   k;
   logic [4:0] sh;
   logic [3:0] g;
   word_type   f;
   word_type   sum;
   word_type   rot;

   always_comb begin
      k  = step_const(step);
      sh = step_shift(step);
      g  = msg_index(step);
      case (step[5:4])
         2'd0:    f = (st_in.b & st_in.c) | (~st_in.b & st_in.d);
         2'd1:    f = (st_in.b & st_in.d) | (st_in.c & ~st_in.d);
         2'd2:    f = st_in.b ^ st_in.c ^ st_in.d;
         default: f = st_in.c ^ (st_in.b | ~st_in.d);
      endcase
      sum = st_in.a + f + k + blk[g];
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
      st_out.a = st_in.d;
      st_out.d = st_in.c;
      st_out.c = st_in.b;
      st_out.b = st_in.b + rot;
   end

endmodule

// ----- sv/md5m_pipe.sv -----
`timescale 1ns / 1ps
module md5m_pipe
   import md5m_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  block_type   in_block,
   input  logic [63:0] in_cand,
   input  state_type   target,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_match,
   output logic [63:0] out_cand
);

   // One register stage per MD5 step; a final stage adds and compares.
   logic      vld_ff [StepCount + 1];
   logic      vld_in [StepCount + 1];
   state_type st_ff  [StepCount];
   state_type st_nx  [StepCount];
   block_type blk_ff [StepCount - 1];
   logic [63:0] cand_ff [StepCount + 1];
   logic      en     [StepCount + 1];
   logic      match_ff;
   state_type digest;

   // A stage moves when its slot is empty or the one after it moves.
   always_comb begin
      en[StepCount] = !vld_ff[StepCount] || out_ready;
      for (int i = StepCount - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i + 1];
      end
      vld_in[0] = en[0] ? in_valid : vld_ff[0];
      for (int i = 1; i <= StepCount; i++) begin
         vld_in[i] = en[i] ? vld_ff[i - 1] : vld_ff[i];
      end
   end
   assign in_ready = en[0];

   md5m_step u_step0 (
      .step   (6'd0),
      .st_in  ('{a: InitA, b: InitB, c: InitC, d: InitD}),
      .blk    (in_block),
      .st_out (st_nx[0])
   );

   for (genvar s = 1; s < StepCount; s++) begin : g_step
      md5m_step u_step (
         .step   (6'(s)),
         .st_in  (st_ff[s - 1]),
         .blk    (blk_ff[s - 1]),
         .st_out (st_nx[s])
      );
   end

   always_comb begin
      digest.a = st_ff[StepCount - 1].a + InitA;
      digest.b = st_ff[StepCount - 1].b + InitB;
      digest.c = st_ff[StepCount - 1].c + InitC;
      digest.d = st_ff[StepCount - 1].d + InitD;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= StepCount; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_in[i];
         end
      end
      if (en[0]) begin
         st_ff[0]   <= st_nx[0];
         blk_ff[0]  <= in_block;
         cand_ff[0] <= in_cand;
      end
      for (int i = 1; i < StepCount; i++) begin
         if (en[i]) begin
            st_ff[i]   <= st_nx[i];
            cand_ff[i] <= cand_ff[i - 1];
            if (i < StepCount - 1) begin
               blk_ff[i] <= blk_ff[i - 1];
            end
         end
      end
      if (en[StepCount]) begin
         match_ff           <= (digest == target);
         cand_ff[StepCount] <= cand_ff[StepCount - 1];
      end
   end

   assign out_valid = vld_ff[StepCount];
   assign out_match = match_ff;
   assign out_cand  = cand_ff[StepCount];

   property p_last_holds;
      @(posedge clock) disable iff (reset)
         out_valid && !out_ready |=> out_valid && $stable(out_cand) && $stable(out_match);
   endproperty
   a_last_holds: assert property (p_last_holds) else $error("result lost under stall");

   property p_fill;
      @(posedge clock) disable iff (reset)
         vld_ff[StepCount - 1] && en[StepCount] |=> out_valid;
   endproperty
   a_fill: assert property (p_fill) else $error("final stage missed an item");

   property p_ready;
      @(posedge clock) disable iff (reset)
         !vld_ff[0] |-> in_ready;
   endproperty
   a_ready: assert property (p_ready) else $error("empty first stage refused input");

endmodule

// ----- sv/md5_candidate_matcher.sv -----
`timescale 1ns / 1ps
// MD5 candidate matcher: every request beat carries a 64-bit candidate suffix. The block hashes
// the two prefix bytes plus the low word_length-2 candidate bytes as one padded MD5 block and
// returns a response beat with match set when the digest equals target_a..target_d, along with
// the candidate echoed in full. The 64 MD5 steps are one register stage each, followed by a
// stage for the final add and compare; the first stage loads at the edge that accepts the
// request, and the block accepts one new candidate every cycle while the response side keeps
// up. Back-pressure on rsp_ready holds the full stages from the output back to the first empty
// stage, without losing or repeating beats. Write the target words,
// word_length (clamped to 3..10) and prefix_bytes through the csr port only while the block is
// idle; the message block is formed from them as a request beat is accepted.
module md5_candidate_matcher
   import md5m_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_match,
   output logic [63:0] rsp_candidate_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Configuration registers.
   state_type   target_ff;
   logic [3:0]  word_length_ff;
   logic [15:0] prefix_ff;
   block_type   block;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff      <= '0;
         word_length_ff <= 4'd8;
         prefix_ff      <= 16'h7564;
      end else if (csr_valid) begin
         case (csr_index)
            RegTargetA:    target_ff.a    <= csr_data;
            RegTargetB:    target_ff.b    <= csr_data;
            RegTargetC:    target_ff.c    <= csr_data;
            RegTargetD:    target_ff.d    <= csr_data;
            RegWordLength: word_length_ff <= csr_data[3:0];
            RegPrefix:     prefix_ff      <= csr_data[15:0];
            default:       ;
         endcase
      end
   end

   // The padded message block is built combinationally from the request beat.
   md5m_block_builder u_builder (
      .candidate    (req_candidate),
      .word_length  (word_length_ff),
      .prefix_bytes (prefix_ff),
      .block        (block)
   );

   md5m_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_block  (block),
      .in_cand   (req_candidate),
      .target    (target_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_match (rsp_match),
      .out_cand  (rsp_candidate_out)
   );

endmodule
